FILE: src/utf8_to_utf16_transcoder_core_defines.svh
// assertion macros for the utf-8 to utf-16 transcoder
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every rising clock edge out of reset
`define U8U16_ASSERT(label, clock, resetn, prop) \
    label: assert property (@(posedge clock) disable iff (!resetn) (prop)) \
        else $error("assertion failed");

// condition that must never be true out of reset
`define U8U16_NEVER(label, clock, resetn, cond) \
    label: assert property (@(posedge clock) disable iff (!resetn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define U8U16_ASSERT(label, clock, resetn, prop)
`define U8U16_NEVER(label, clock, resetn, cond)

`endif

`endif

FILE: src/u8u16_pkg.sv
package u8u16_pkg;

    // result status codes
    typedef enum logic [2:0] {
        ST_UNIT     = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_TRUNC    = 3'd2,
        ST_BAD_CONT = 3'd3,
        ST_BAD_CP   = 3'd4
    } status_t;

    // decoder state carried between bytes
    typedef struct packed {
        logic [1:0]  bytes_needed;
        logic [2:0]  sequence_length;
        logic [20:0] point_accum;
        logic        continuation_bad;
        logic        skipping;
    } dec_state_t;

    // one utf-16 result word
    typedef struct packed {
        logic [15:0] code_unit;
        status_t     status;
        logic        pair_done;
        logic        text_done;
    } result_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [20:0] CP_MIN_2    = 21'h00080;
    localparam logic [20:0] CP_MIN_3    = 21'h00800;
    localparam logic [20:0] CP_MIN_4    = 21'h10000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SUR_LO   = 21'h0D800;
    localparam logic [20:0] CP_SUR_HI   = 21'h0DFFF;
    localparam logic [20:0] CP_BMP_MAX  = 21'h0FFFF;
    localparam logic [5:0]  HI_SUR_TAG  = 6'b110110;
    localparam logic [5:0]  LO_SUR_TAG  = 6'b110111;

endpackage

FILE: src/u8u16_if.sv
// byte channel and code unit channel
interface u8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [2:0]  status;
    logic        pair_done;
    logic        text_done;

    modport source (
        output valid, output code_unit, output status, output pair_done,
        output text_done, input ready
    );
    modport sink (
        input valid, input code_unit, input status, input pair_done,
        input text_done, output ready
    );
endinterface

FILE: src/u8u16_decode.sv
module u8u16_decode
    import u8u16_pkg::*;
(
    input  dec_state_t  state,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output dec_state_t  state_next,
    output logic [1:0]  num_results,
    output result_t     res0,
    output result_t     res1
);

    logic [20:0] accum;
    logic [20:0] cp;
    logic [20:0] v;
    logic [1:0]  need;
    logic        cbad;
    logic        emit_point;
    logic        emit_error;
    status_t     err_code;
    logic        overlong;

    // continuation slot arithmetic
    assign accum = {state.point_accum[14:0], text_byte[5:0]};
    assign need  = state.bytes_needed - 2'd1;
    assign cbad  = state.continuation_bad | (text_byte[7:6] != 2'b10);

    always_comb
    begin
        overlong = ((state.sequence_length == 3'd2) && (accum < CP_MIN_2)) ||
                   ((state.sequence_length == 3'd3) && (accum < CP_MIN_3)) ||
                   ((state.sequence_length == 3'd4) && (accum < CP_MIN_4));
    end

    // byte classification and state update
    always_comb
    begin
        state_next = state;
        emit_point = 1'b0;
        emit_error = 1'b0;
        err_code   = ST_BAD_LEAD;
        cp         = {13'd0, text_byte};
        if (state.skipping)
        begin
            if (end_of_text)
                state_next = '0;
        end
        else if (state.bytes_needed == 2'd0)
        begin
            if (!text_byte[7])
            begin
                emit_point = 1'b1;
            end
            else if ((text_byte[7:5] == 3'b110) || (text_byte[7:4] == 4'b1110) ||
                     (text_byte[7:3] == 5'b11110))
            begin
                if (text_byte[7:5] == 3'b110)
                begin
                    state_next.point_accum     = {16'd0, text_byte[4:0]};
                    state_next.sequence_length = 3'd2;
                    state_next.bytes_needed    = 2'd1;
                end
                else if (text_byte[7:4] == 4'b1110)
                begin
                    state_next.point_accum     = {17'd0, text_byte[3:0]};
                    state_next.sequence_length = 3'd3;
                    state_next.bytes_needed    = 2'd2;
                end
                else
                begin
                    state_next.point_accum     = {18'd0, text_byte[2:0]};
                    state_next.sequence_length = 3'd4;
                    state_next.bytes_needed    = 2'd3;
                end
                state_next.continuation_bad = 1'b0;
                if (end_of_text)
                begin
                    emit_error = 1'b1;
                    err_code   = ST_TRUNC;
                end
            end
            else
            begin
                emit_error = 1'b1;
                err_code   = ST_BAD_LEAD;
            end
        end
        else
        begin
            state_next.point_accum      = accum;
            state_next.bytes_needed     = need;
            state_next.continuation_bad = cbad;
            cp                          = accum;
            if (need != 2'd0)
            begin
                if (end_of_text)
                begin
                    emit_error = 1'b1;
                    err_code   = ST_TRUNC;
                end
            end
            else if (cbad)
            begin
                emit_error = 1'b1;
                err_code   = ST_BAD_CONT;
            end
            else if (overlong || (accum > CP_MAX) ||
                     ((accum >= CP_SUR_LO) && (accum <= CP_SUR_HI)))
            begin
                emit_error = 1'b1;
                err_code   = ST_BAD_CP;
            end
            else
            begin
                state_next = '0;
                emit_point = 1'b1;
            end
        end
        if (emit_error)
        begin
            state_next          = '0;
            state_next.skipping = !end_of_text;
        end
    end

    // result words
    assign v = cp - CP_MIN_4;

    always_comb
    begin
        num_results = 2'd0;
        res0        = '0;
        res1        = '0;
        if (emit_error)
        begin
            num_results    = 2'd1;
            res0.status    = err_code;
            res0.pair_done = 1'b1;
            res0.text_done = 1'b1;
        end
        else if (emit_point)
        begin
            if (cp <= CP_BMP_MAX)
            begin
                num_results    = 2'd1;
                res0.code_unit = cp[15:0];
                res0.status    = ST_UNIT;
                res0.pair_done = 1'b1;
                res0.text_done = end_of_text;
            end
            else
            begin
                num_results    = 2'd2;
                res0.code_unit = {HI_SUR_TAG, v[19:10]};
                res0.status    = ST_UNIT;
                res1.code_unit = {LO_SUR_TAG, v[9:0]};
                res1.status    = ST_UNIT;
                res1.pair_done = 1'b1;
                res1.text_done = end_of_text;
            end
        end
    end

endmodule

FILE: src/utf8_to_utf16_transcoder_core.sv
// channel | modport      | payload                                    | per word
// text    | byte sink    | text_byte[7:0], end_of_text                | one utf-8 byte
// units   | unit source  | code_unit[15:0], status[2:0], pair_done,   | one utf-16 unit
//         |              | text_done                                  | or error
// one byte is taken per cycle while text.ready is high; a byte is decoded in the
// cycle it is accepted and its results land in a four-word result queue, first
// word visible next cycle; the queue drains one word per cycle while units.ready
// is high, and a surrogate pair is two words; text.ready is high while the queue
// has room for two words; it does not depend on units.ready in the same cycle
// rst_n clears the decoder state and empties the queue
`include "utf8_to_utf16_transcoder_core_defines.svh"

module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    u8u16_byte_if.sink   text,
    u8u16_unit_if.source units
);

    dec_state_t        state_reg;
    dec_state_t        state_next;
    logic [1:0]        num_results;
    result_t           res0;
    result_t           res1;
    result_t           queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  push_cnt;
    logic              accept;
    logic              pop;
    result_t           head;

    u8u16_decode u_decode (
        .state       (state_reg),
        .text_byte   (text.text_byte),
        .end_of_text (text.end_of_text),
        .state_next  (state_next),
        .num_results (num_results),
        .res0        (res0),
        .res1        (res1)
    );

    // handshakes
    assign text.ready = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign accept     = text.valid & text.ready;
    assign pop        = units.valid & units.ready;
    assign push_cnt   = accept ? CNT_W'(num_results) : '0;

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (accept)
            state_reg <= state_next;
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + push_cnt - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != '0)
            queue_reg[wr_ptr_reg] <= res0;
        if (push_cnt == CNT_W'(2))
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    // output word
    assign head            = queue_reg[rd_ptr_reg];
    assign units.valid     = (count_reg != '0);
    assign units.code_unit = head.code_unit;
    assign units.status    = head.status;
    assign units.pair_done = head.pair_done;
    assign units.text_done = head.text_done;

    // checks
    `U8U16_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_W'(QUEUE_DEPTH))
    `U8U16_ASSERT(a_error_word, clk, rst_n,
        (units.valid && (units.status != ST_UNIT)) |->
        (units.pair_done && units.text_done && (units.code_unit == 16'd0)))
    `U8U16_ASSERT(a_pair_order, clk, rst_n,
        (accept && (num_results == 2'd2)) |-> (!res0.pair_done && res1.pair_done))
    `U8U16_ASSERT(a_skip_after_error, clk, rst_n,
        (accept && (num_results != 2'd0) && (res0.status != ST_UNIT) &&
         !text.end_of_text) |=> state_reg.skipping)

endmodule

FILE: bench/u8u16_unit_compare.sv
`timescale 1ns / 1ps

// watches both channels, predicts the utf-16 words and compares them
module u8u16_unit_compare
    import u8u16_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    u8u16_byte_if text,
    u8u16_unit_if units,
    output int    mismatches,
    output int    pending,
    output int    checked
);

    // decoder state of the predictor
    logic [1:0]  cont_left;
    logic [2:0]  seq_len;
    logic [20:0] cp_accum;
    logic        cont_bad;
    logic        drop_rest;

    // utf-16 words still owed by the block, oldest first
    result_t unit_expect_q[$];

    task automatic clear_seq();
        cont_left = '0;
        seq_len   = '0;
        cp_accum  = '0;
        cont_bad  = 1'b0;
    endtask

    task automatic push_unit(input logic [15:0] cu, input status_t st,
                             input logic pd, input logic td);
        result_t r;
        r.code_unit   = cu;
        r.status      = st;
        r.pair_done   = pd;
        r.text_done   = td;
        unit_expect_q = {unit_expect_q, r};
    endtask

    // an error closes the text; drop bytes up to the end flag unless this was it
    task automatic push_error(input status_t st, input logic last);
        clear_seq();
        drop_rest = !last;
        push_unit(16'h0000, st, 1'b1, 1'b1);
    endtask

    // one unit inside the bmp, a surrogate pair above it
    task automatic push_point(input logic [20:0] cp, input logic last);
        logic [20:0] v;
        if (cp <= CP_BMP_MAX)
        begin
            push_unit(cp[15:0], ST_UNIT, 1'b1, last);
        end
        else
        begin
            v = cp - CP_MIN_4;
            push_unit({HI_SUR_TAG, v[19:10]}, ST_UNIT, 1'b0, 1'b0);
            push_unit({LO_SUR_TAG, v[9:0]}, ST_UNIT, 1'b1, last);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [20:0] cp;
        logic        overlong;
        if (drop_rest)
        begin
            // skipping after an error
            if (last)
            begin
                drop_rest = 1'b0;
                clear_seq();
            end
        end
        else if (cont_left == 2'd0)
        begin
            // lead byte
            if (!b[7])
            begin
                push_point({13'd0, b}, last);
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    cp_accum = {16'd0, b[4:0]};
                    seq_len  = 3'd2;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cp_accum = {17'd0, b[3:0]};
                    seq_len  = 3'd3;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cp_accum = {18'd0, b[2:0]};
                    seq_len  = 3'd4;
                end
                else
                begin
                    seq_len = 3'd0;
                end
                if (seq_len == 3'd0)
                begin
                    push_error(ST_BAD_LEAD, last);
                end
                else if (last)
                begin
                    push_error(ST_TRUNC, last);
                end
                else
                begin
                    cont_left = 2'(seq_len - 3'd1);
                    cont_bad  = 1'b0;
                end
            end
        end
        else
        begin
            // continuation slot, a bad one still takes its place
            if (b[7:6] != 2'b10)
            begin
                cont_bad = 1'b1;
            end
            cp_accum  = {cp_accum[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left != 2'd0)
            begin
                if (last)
                begin
                    push_error(ST_TRUNC, last);
                end
            end
            else if (cont_bad)
            begin
                push_error(ST_BAD_CONT, last);
            end
            else
            begin
                cp = cp_accum;
                overlong = (seq_len == 3'd2 && cp < CP_MIN_2) ||
                           (seq_len == 3'd3 && cp < CP_MIN_3) ||
                           (seq_len == 3'd4 && cp < CP_MIN_4);
                if (overlong || cp > CP_MAX || (cp >= CP_SUR_LO && cp <= CP_SUR_HI))
                begin
                    push_error(ST_BAD_CP, last);
                end
                else
                begin
                    clear_seq();
                    push_point(cp, last);
                end
            end
        end
    endtask

    // compare the word leaving the block, then predict from the byte entering it
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_seq();
            drop_rest = 1'b0;
            unit_expect_q.delete();
            mismatches = 0;
            checked    = 0;
        end
        else
        begin
            if (units.valid && units.ready)
            begin
                checked++;
                if (unit_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected word: unit %h status %0d pair %b text %b",
                                 units.code_unit, units.status, units.pair_done,
                                 units.text_done);
                    end
                end
                else
                begin
                    want = unit_expect_q.pop_front();
                    if (units.code_unit !== want.code_unit || units.status !== want.status ||
                        units.pair_done !== want.pair_done ||
                        units.text_done !== want.text_done)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("word mismatch: got unit %h status %0d pair %b text %b",
                                     units.code_unit, units.status, units.pair_done,
                                     units.text_done);
                            $display("               want unit %h status %0d pair %b text %b",
                                     want.code_unit, want.status, want.pair_done,
                                     want.text_done);
                        end
                    end
                end
            end
            if (text.valid && text.ready)
            begin
                decode_byte(text.text_byte, text.end_of_text);
            end
        end
        pending = unit_expect_q.size();
    end

endmodule

FILE: bench/utf8_to_utf16_transcoder_core_test.sv
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_core_test
    import u8u16_pkg::*;
();

    localparam int RANDOM_BYTES = 400;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } text_word_t;

    logic clk;
    logic rst_n;

    u8u16_byte_if text();
    u8u16_unit_if units();

    int mismatch_count;
    int pending_count;
    int checked_count;

    // planned byte stream and the text being built
    text_word_t byte_plan[$];
    logic [7:0] text_buf[$];
    int         text_count;
    int         directed_size;

    // idling controls, partly shared with the receiver, and the watchdog count
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int stall_count;

    utf8_to_utf16_transcoder_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .units (units)
    );

    u8u16_unit_compare i_compare (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .units      (units),
        .mismatches (mismatch_count),
        .pending    (pending_count),
        .checked    (checked_count)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic put_raw(input logic [7:0] b);
        text_buf = {text_buf, b};
    endtask

    // utf-8 encoding with a forced length, so overlong forms come out too
    task automatic put_char(input logic [20:0] cp, input int len);
        case (len)
            1: put_raw({1'b0, cp[6:0]});
            2:
            begin
                put_raw({3'b110, cp[10:6]});
                put_raw({2'b10, cp[5:0]});
            end
            3:
            begin
                put_raw({4'b1110, cp[15:12]});
                put_raw({2'b10, cp[11:6]});
                put_raw({2'b10, cp[5:0]});
            end
            default:
            begin
                put_raw({5'b11110, cp[20:18]});
                put_raw({2'b10, cp[17:12]});
                put_raw({2'b10, cp[11:6]});
                put_raw({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // end flag goes on the final byte of the text
    task automatic close_text();
        text_word_t w;
        for (int j = 0; j < text_buf.size(); j++)
        begin
            w.value   = text_buf[j];
            w.last    = (j == text_buf.size() - 1);
            byte_plan = {byte_plan, w};
        end
        if (text_buf.size() != 0)
            text_count++;
        text_buf.delete();
    endtask

    // legal code point for a given sequence length
    function automatic logic [20:0] valid_point(input int len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= CP_SUR_LO && cp <= CP_SUR_HI)
                    cp = cp + 21'h800;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // one malformed character of a random kind
    task automatic put_broken_char();
        int         len;
        int         pos;
        logic [7:0] rb;
        case ($urandom_range(0, 4))
            0:
            begin
                if ($urandom_range(0, 1))
                    put_raw(8'($urandom_range('h80, 'hBF)));
                else
                    put_raw(8'($urandom_range('hF8, 'hFF)));
            end
            1:
            begin
                len = $urandom_range(2, 4);
                if (len == 2)
                    put_char(21'($urandom_range(0, 'h7F)), 2);
                else if (len == 3)
                    put_char(21'($urandom_range(0, 'h7FF)), 3);
                else
                    put_char(21'($urandom_range(0, 'hFFFF)), 4);
            end
            2: put_char(21'($urandom_range('hD800, 'hDFFF)), 3);
            3: put_char(21'($urandom_range('h110000, 'h1FFFFF)), 4);
            default:
            begin
                len = $urandom_range(2, 4);
                put_char(valid_point(len), len);
                pos = text_buf.size() - $urandom_range(1, len - 1);
                rb = 8'($urandom);
                case ($urandom_range(0, 2))
                    0: rb[7:6] = 2'b00;
                    1: rb[7:6] = 2'b01;
                    default: rb[7:6] = 2'b11;
                endcase
                text_buf[pos] = rb;
            end
        endcase
    endtask

    task automatic build_plan();
        int mode;
        int n_chars;
        int len;
        // every sequence length, the longer three at their top values, ending in a pair
        put_char(21'h0, 1);
        put_char(21'h7FF, 2);
        put_char(21'hFFFF, 3);
        put_char(21'h10FFFF, 4);
        close_text();
        // bad lead, then the rest of the text is dropped
        put_raw(8'hFF);
        put_raw(8'h41);
        close_text();
        // overlong form on the final byte
        put_char(21'h0, 2);
        close_text();
        // surrogate, then skipping to the end flag
        put_char(21'hD800, 3);
        put_raw(8'h7F);
        close_text();
        // bad continuation reported when the sequence completes
        put_raw(8'hC2);
        put_raw(8'h41);
        close_text();
        // text ends inside a sequence that also has a bad continuation
        put_raw(8'hE0);
        put_raw(8'hC1);
        close_text();
        // above the code point range
        put_char(21'h110000, 4);
        close_text();
        // bad lead as the last byte
        put_raw(8'h80);
        close_text();
        directed_size = byte_plan.size();

        // random texts: mostly well formed, some broken, some noise
        while (byte_plan.size() < directed_size + RANDOM_BYTES)
        begin
            mode    = $urandom_range(0, 99);
            n_chars = $urandom_range(1, 6);
            if (mode >= 90)
            begin
                repeat ($urandom_range(1, 8))
                    put_raw(8'($urandom));
            end
            else
            begin
                for (int k = 0; k < n_chars; k++)
                begin
                    if (mode >= 70 && mode < 80 && k == n_chars / 2)
                        put_broken_char();
                    else
                    begin
                        len = $urandom_range(1, 4);
                        put_char(valid_point(len), len);
                    end
                end
                if (mode >= 80)
                begin
                    // cut the final sequence short
                    len = $urandom_range(2, 4);
                    put_char(valid_point(len), len);
                    repeat ($urandom_range(1, len - 1))
                        void'(text_buf.pop_back());
                end
            end
            close_text();
        end
    endtask

    // offer one byte word, entered and left at a falling edge
    // ready only moves at a rising edge, so its value here holds for the next one
    task automatic send_word(input text_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            text.valid <= 1'b0;
            @(negedge clk);
        end
        text.valid       <= 1'b1;
        text.text_byte   <= w.value;
        text.end_of_text <= w.last;
        while (!text.ready)
            @(negedge clk);
        @(negedge clk);
    endtask

    // receiver with random stalls and long holds on request
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        units.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                units.ready <= 1'b0;
            end
            else
                units.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no word moving
    initial stall_count = 0;
    always @(posedge clk)
    begin
        if ((text.valid && text.ready) || (units.valid && units.ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        int phase;
        text.valid       = 1'b0;
        text.text_byte   = 8'h00;
        text.end_of_text = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_req         = 0;
        text_count       = 0;
        rst_n            = 1'b0;
        build_plan();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < byte_plan.size(); i++)
        begin
            // four idling mixes over the run
            phase = (i * 4) / byte_plan.size();
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct  = 10;
                    recv_stall_pct = 10;
                end
            endcase
            // long output holds while bytes keep coming
            if (i == byte_plan.size() / 8 || i == (byte_plan.size() * 5) / 8)
                hold_req++;
            send_word(byte_plan[i]);
        end
        text.valid <= 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d texts, checked %0d result words",
                 byte_plan.size(), text_count, checked_count);
        $display("covered all statuses, surrogate pairs, skipping, four idle mixes, two holds");
        if (mismatch_count == 0 && pending_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
